FILE: rtl/core/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants for the touch slot tracker and scaler.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam logic [4:0] KIND_SYNC = 5'd0;
   localparam logic [4:0] KIND_KEY  = 5'd1;
   localparam logic [4:0] KIND_ABS  = 5'd3;

   localparam logic [9:0] CODE_REPORT    = 10'd0;
   localparam logic [9:0] CODE_ABS_X     = 10'd0;
   localparam logic [9:0] CODE_ABS_Y     = 10'd1;
   localparam logic [9:0] CODE_SLOT      = 10'h2f;
   localparam logic [9:0] CODE_MT_X      = 10'h35;
   localparam logic [9:0] CODE_MT_Y      = 10'h36;
   localparam logic [9:0] CODE_TRACK     = 10'h39;
   localparam logic [9:0] CODE_TOUCH_KEY = 10'd330;

   localparam logic [2:0] REG_MIN_X  = 3'd0;
   localparam logic [2:0] REG_MAX_X  = 3'd1;
   localparam logic [2:0] REG_MIN_Y  = 3'd2;
   localparam logic [2:0] REG_MAX_Y  = 3'd3;
   localparam logic [2:0] REG_VIEW_W = 3'd4;
   localparam logic [2:0] REG_VIEW_H = 3'd5;
   localparam logic [2:0] REG_MODE   = 3'd6;
   localparam logic [2:0] REG_SLOTS  = 3'd7;

   // command operations handed from front to back
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_TRACK = 3'd1;
   localparam logic [2:0] OP_X     = 3'd2;
   localparam logic [2:0] OP_Y     = 3'd3;
   localparam logic [2:0] OP_SYNC  = 3'd4;

   // classified command handed from front to back
   typedef struct packed {
      logic              sync;     // sync report: walk slots
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic              active;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] min_x;
      logic signed [15:0] max_x;
      logic signed [15:0] min_y;
      logic signed [15:0] max_y;
      logic        [12:0] view_w;
      logic        [12:0] view_h;
      logic        [3:0]  mode;
      logic        [4:0]  slots;
   } cfg_type;

   typedef struct packed {
      logic              point_valid;
      logic [3:0]        slot_index;
      logic signed [15:0] disp_x;
      logic signed [15:0] disp_y;
      logic              last_point;
   } rsp_type;

   function automatic logic signed [15:0] sat16_32(input logic signed [31:0] v);
      if (v > 32'sd32767) return 16'sh7fff;
      if (v < -32'sd32768) return -16'sh8000;
      return v[15:0];
   endfunction

endpackage

FILE: rtl/core/tst_if.sv
// ----------------------------------------------------------------------------
// tst_req_if / tst_rsp_if
// Valid/ready channels for raw events and reported points.
// ----------------------------------------------------------------------------
interface tst_req_if;
   logic              valid;
   logic              ready;
   logic [4:0]        kind;
   logic [9:0]        event_code;
   logic signed [31:0] event_value;
   modport source (output valid, kind, event_code, event_value, input ready);
   modport sink   (input valid, kind, event_code, event_value, output ready);
endinterface

interface tst_rsp_if;
   logic              valid;
   logic              ready;
   logic              point_valid;
   logic [3:0]        slot_index;
   logic signed [15:0] disp_x;
   logic signed [15:0] disp_y;
   logic              last_point;
   modport source (output valid, point_valid, slot_index, disp_x, disp_y, last_point,
                   input ready);
   modport sink   (input valid, point_valid, slot_index, disp_x, disp_y, last_point,
                   output ready);
endinterface

FILE: rtl/core/tst_div.sv
// ----------------------------------------------------------------------------
// tst_div
// Restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tst_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [17:0] den,
   output logic               done,
   output logic signed [31:0] quo
);
   logic [31:0] n_ff, n_in;
   logic [31:0] r_ff, r_in;
   logic [16:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        fin_ff;
   logic [32:0] trial;

   always_comb begin
      n_in = n_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff, n_ff[31]} - {16'd0, d_ff};
      if (start) begin
         n_in    = num[31] ? 32'(-num) : num;
         d_in    = den[17] ? 17'(-den) : den[16:0];
         neg_in  = num[31] ^ den[17];
         r_in    = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            n_in = {n_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], n_ff[31]};
            n_in = {n_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in;
         // a restart on the final step drops the old result
         fin_ff <= busy_ff && cnt_ff == 6'd1 && !start;
      end
   end

   assign quo = neg_ff ? -$signed(n_ff) : $signed(n_ff);
   assign done = fin_ff;
endmodule

FILE: rtl/core/tst_front.sv
// ----------------------------------------------------------------------------
// tst_front
// Decodes raw events, keeps current slot, emits classified commands.
// ----------------------------------------------------------------------------
module tst_front #(
   parameter int MAX_SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   tst_req_if.sink            req,
   input  tst_pkg::cfg_type   cfg,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output tst_pkg::cmd_type   cmd,
   output logic [$clog2(MAX_SLOTS+1)-1:0] cmd_slot,
   output logic [2:0]         cmd_op
);
   import tst_pkg::*;
   localparam int SW = $clog2(MAX_SLOTS+1);

   logic [SW-1:0] cur_ff, cur_in, n, w;
   logic multi;
   logic signed [31:0] v;

   always_comb begin
      multi = cfg.mode[3];
      if (cfg.slots == 5'd0) n = SW'(1);
      else if (32'(cfg.slots) > MAX_SLOTS) n = SW'(MAX_SLOTS);
      else n = SW'(cfg.slots);
      w = (cur_ff < n) ? cur_ff : n - SW'(1);
      v = req.event_value;
      cur_in = cur_ff;
      cmd_op = OP_NONE;
      cmd_slot = w;
      cmd.sync = 1'b0;
      cmd.x = sat16_32(v);
      cmd.y = sat16_32(v);
      cmd.active = !v[31];
      if (req.kind == KIND_ABS) begin
         if (multi) begin
            if (req.event_code == CODE_SLOT) begin
               if (v[31]) cur_in = '0;
               else if ($unsigned(v) > 32'(n - SW'(1))) cur_in = n - SW'(1);
               else cur_in = SW'(v);
            end else if (req.event_code == CODE_TRACK) cmd_op = OP_TRACK;
            else if (req.event_code == CODE_MT_X) cmd_op = OP_X;
            else if (req.event_code == CODE_MT_Y) cmd_op = OP_Y;
         end else begin
            cmd_slot = '0;
            if (req.event_code == CODE_ABS_X) cmd_op = OP_X;
            else if (req.event_code == CODE_ABS_Y) cmd_op = OP_Y;
         end
      end else if (req.kind == KIND_KEY) begin
         cmd_slot = '0;
         cmd.active = v != 32'sd0;
         if (!multi && req.event_code == CODE_TOUCH_KEY) cmd_op = OP_TRACK;
      end else if (req.kind == KIND_SYNC && req.event_code == CODE_REPORT) begin
         cmd_op = OP_SYNC;
         cmd.sync = 1'b1;
      end
   end

   assign cmd_valid = req.valid && cmd_op != OP_NONE;
   assign req.ready = cmd_ready || cmd_op == OP_NONE;

   always_ff @(posedge clock) begin
      if (reset) cur_ff <= '0;
      else if (req.valid && req.ready) cur_ff <= cur_in;
   end
endmodule

FILE: rtl/core/tst_back.sv
// ----------------------------------------------------------------------------
// tst_back
// Slot store and sync walk: swap, scale by division, mirror, saturate.
// ----------------------------------------------------------------------------
module tst_back #(
   parameter int MAX_SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  tst_pkg::cfg_type   cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  logic [2:0]         q_op,
   input  logic [$clog2(MAX_SLOTS+1)-1:0] q_slot,
   input  tst_pkg::cmd_type   q_cmd,
   tst_rsp_if.source          rsp
);
   import tst_pkg::*;
   localparam int SW = $clog2(MAX_SLOTS+1);
   localparam int IW = $clog2(MAX_SLOTS > 1 ? MAX_SLOTS : 2);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DIVX = 6'b000100,
      S_DIVY = 6'b001000, S_EMIT = 6'b010000, S_LAST = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [MAX_SLOTS-1:0] act_ff;
   logic signed [15:0] rx_ff [MAX_SLOTS];
   logic signed [15:0] ry_ff [MAX_SLOTS];
   logic [SW-1:0] s_ff, s_in, n;
   logic any_ff, any_in;
   logic signed [31:0] px_ff, py_ff;
   logic [SW-1:0] lastv;
   rsp_type o_ff, o_in;
   logic ov_ff, ov_in;

   // divider
   logic dstart, ddone;
   logic signed [31:0] dnum, dquo;
   logic signed [17:0] dden;
   tst_div u_div (.clock, .reset, .start(dstart), .num(dnum), .den(dden),
                  .done(ddone), .quo(dquo));

   logic swap;
   logic signed [16:0] ax, ay, lx, hx, ly, hy, lo, hi, vv;
   logic [12:0] sz;
   logic scaled_x, scaled_y;
   logic signed [31:0] prod, mir;
   logic signed [31:0] res_x, res_y;
   logic [SW-1:0] si;
   logic [IW-1:0] ri, wi;

   always_comb begin
      if (cfg.slots == 5'd0) n = SW'(1);
      else if (32'(cfg.slots) > MAX_SLOTS) n = SW'(MAX_SLOTS);
      else n = SW'(cfg.slots);
      si = (s_ff < SW'(MAX_SLOTS)) ? s_ff : '0;
      ri = si[IW-1:0];
      wi = q_slot[IW-1:0];
      swap = cfg.mode[0];
      ax = swap ? 17'(ry_ff[ri]) : 17'(rx_ff[ri]);
      ay = swap ? 17'(rx_ff[ri]) : 17'(ry_ff[ri]);
      lx = swap ? 17'(cfg.min_y) : 17'(cfg.min_x);
      hx = swap ? 17'(cfg.max_y) : 17'(cfg.max_x);
      ly = swap ? 17'(cfg.min_x) : 17'(cfg.min_y);
      hy = swap ? 17'(cfg.max_x) : 17'(cfg.max_y);
      scaled_x = hx > lx;
      scaled_y = hy > ly;
      // y division is launched on the cycle the x result lands
      if (st_ff == S_DIVX) begin
         lo = ly; hi = hy; vv = ay; sz = cfg.view_h;
      end else begin
         lo = lx; hi = hx; vv = ax; sz = cfg.view_w;
      end
      prod = 32'(18'(vv) - 18'(lo)) * $signed({1'b0, sz} - 14'sd1);
      dnum = prod;
      dden = 18'(hi) - 18'(lo);
      mir = 32'($signed({1'b0, cfg.view_w})) - 32'sd1;
      res_x = scaled_x ? dquo : 32'(ax);
      res_y = scaled_y ? dquo : 32'(ay);
   end

   assign q_ready = st_ff == S_IDLE && (!ov_ff || rsp.ready || !q_cmd.sync);

   always_comb begin
      st_in = st_ff; s_in = s_ff; any_in = any_ff; dstart = 1'b0;
      o_in = o_ff; ov_in = ov_ff && !rsp.ready;
      case (st_ff)
         S_IDLE: if (q_valid && q_ready && q_cmd.sync) begin
            st_in = S_SCAN; s_in = '0; any_in = 1'b0;
         end
         S_SCAN: begin
            if (s_ff >= n) begin
               if (!any_ff) st_in = S_LAST;
               else st_in = S_IDLE;
            end else if (act_ff[ri]) begin
               st_in = S_DIVX; dstart = 1'b1;
            end else s_in = s_ff + SW'(1);
         end
         S_DIVX: if (ddone || !scaled_x) begin
            st_in = S_DIVY; dstart = 1'b1;
         end
         S_DIVY: if (ddone || !scaled_y) st_in = S_EMIT;
         S_EMIT: if (!ov_in) begin
            o_in.point_valid = 1'b1;
            o_in.slot_index = 4'(s_ff);
            o_in.disp_x = sat16_32(cfg.mode[1] ? mir - px_ff : px_ff);
            o_in.disp_y = sat16_32(cfg.mode[2] ? 32'($signed({1'b0, cfg.view_h})) - 32'sd1
                                               - py_ff : py_ff);
            o_in.last_point = lastv == s_ff;
            ov_in = 1'b1; any_in = 1'b1;
            s_in = s_ff + SW'(1);
            st_in = (lastv == s_ff) ? S_IDLE : S_SCAN;
         end
         S_LAST: if (!ov_in) begin
            o_in = '0; o_in.last_point = 1'b1; ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // highest active slot below n
   always_comb begin
      lastv = '0;
      for (int i = 0; i < MAX_SLOTS; i++)
         if (act_ff[i] && SW'(i) < n) lastv = SW'(i);
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_DIVX && (ddone || !scaled_x)) px_ff <= res_x;
      if (st_ff == S_DIVY && (ddone || !scaled_y)) py_ff <= res_y;
      o_ff <= o_in;
      if (reset) begin
         st_ff <= S_IDLE; s_ff <= '0; any_ff <= 1'b0; ov_ff <= 1'b0; act_ff <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            rx_ff[i] <= '0; ry_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in; s_ff <= s_in; any_ff <= any_in; ov_ff <= ov_in;
         if (q_valid && q_ready && !q_cmd.sync) begin
            if (q_op == OP_X) rx_ff[wi] <= q_cmd.x;
            if (q_op == OP_Y) ry_ff[wi] <= q_cmd.y;
            if (q_op == OP_TRACK) act_ff[wi] <= q_cmd.active;
         end
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.point_valid = o_ff.point_valid;
   assign rsp.slot_index = o_ff.slot_index;
   assign rsp.disp_x = o_ff.disp_x;
   assign rsp.disp_y = o_ff.disp_y;
   assign rsp.last_point = o_ff.last_point;
endmodule

FILE: rtl/core/touch_slot_tracker_scaler.sv
// ----------------------------------------------------------------------------
// touch_slot_tracker_scaler
// Multi-touch slot tracker with linear scaling to display coordinates.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  req      in   valid/ready     kind, event_code, event_value
//  rsp      out  valid/ready     point_valid, slot_index, disp_x, disp_y, last_point
//  csr      in   write enable    index, 16-bit data
//
// A request that maps to a command enters the two-entry queue on its accept edge and
// is applied by the back end once it is at the head and the back end is idle. A sync
// report walks slots_in_use slots; each active slot waits on the shared 32-step
// divider for x and then for y, unless that axis's range does not scale, and an
// empty frame ends with a marker. Reset is synchronous and clears all slot state
// at once; rsp stalls hold the walk, the queue keeps req.
module touch_slot_tracker_scaler #(
   parameter int MAX_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tst_req_if.sink     req,
   tst_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tst_pkg::*;
   localparam int SW = $clog2(MAX_SLOTS+1);
   localparam int QW = 3 + SW + $bits(cmd_type);

   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x <= 16'sd0; cfg_ff.max_x <= 16'sd4095;
         cfg_ff.min_y <= 16'sd0; cfg_ff.max_y <= 16'sd4095;
         cfg_ff.view_w <= 13'd1024; cfg_ff.view_h <= 13'd768;
         cfg_ff.mode <= 4'd8; cfg_ff.slots <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_X:  cfg_ff.min_x <= csr_wdata;
            REG_MAX_X:  cfg_ff.max_x <= csr_wdata;
            REG_MIN_Y:  cfg_ff.min_y <= csr_wdata;
            REG_MAX_Y:  cfg_ff.max_y <= csr_wdata;
            REG_VIEW_W: cfg_ff.view_w <= csr_wdata[12:0];
            REG_VIEW_H: cfg_ff.view_h <= csr_wdata[12:0];
            REG_MODE:   cfg_ff.mode <= csr_wdata[3:0];
            REG_SLOTS:  cfg_ff.slots <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic f_valid, f_ready;
   cmd_type f_cmd;
   logic [SW-1:0] f_slot;
   logic [2:0] f_op;

   tst_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
      .clock, .reset, .req, .cfg(cfg_ff), .cmd_valid(f_valid), .cmd_ready(f_ready),
      .cmd(f_cmd), .cmd_slot(f_slot), .cmd_op(f_op));

   // two-entry queue
   logic [QW-1:0] q_ff [2];
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic b_valid, b_ready;
   logic [QW-1:0] head;
   cmd_type b_cmd;
   logic [SW-1:0] b_slot;
   logic [2:0] b_op;

   assign f_ready = cnt_ff != 2'd2;
   assign b_valid = cnt_ff != 2'd0;
   assign head = q_ff[rd_ff];
   assign {b_op, b_slot, b_cmd} = head;

   always_ff @(posedge clock) begin
      if (f_valid && f_ready) q_ff[wr_ff] <= {f_op, f_slot, f_cmd};
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (f_valid && f_ready) wr_ff <= !wr_ff;
         if (b_valid && b_ready) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(f_valid && f_ready) - 2'(b_valid && b_ready);
      end
   end

   tst_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_valid(b_valid), .q_ready(b_ready),
      .q_op(b_op), .q_slot(b_slot), .q_cmd(b_cmd), .rsp);
endmodule

FILE: rtl/core/tst_checker.sv
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks on the response channel.
// ----------------------------------------------------------------------------
module tst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_point_valid,
   input logic [3:0]  rsp_slot_index,
   input logic [15:0] rsp_disp_x,
   input logic        rsp_last_point
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_disp_x))
      else $error("rsp dropped while stalled");
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> rsp_last_point && rsp_slot_index == 4'd0
      && rsp_disp_x == 16'd0) else $error("bad empty marker");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_point_valid && !rsp_last_point
      |=> !rsp_valid || rsp_point_valid) else $error("marker inside frame");
endmodule

bind touch_slot_tracker_scaler tst_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_point_valid(rsp.point_valid), .rsp_slot_index(rsp.slot_index),
   .rsp_disp_x(rsp.disp_x), .rsp_last_point(rsp.last_point));

FILE: test/tst_tb_if.sv
// ----------------------------------------------------------------------------
// tst_tb_if
// Testbench-side channel helpers for the touch slot tracker bench.
// ----------------------------------------------------------------------------
// The channel interfaces themselves come with the RTL (tst_req_if, tst_rsp_if);
// this file only carries the request record that the bench queues up.
package tst_tb_pkg;

   typedef struct packed {
      logic [4:0]         kind;
      logic [9:0]         event_code;
      logic signed [31:0] event_value;
   } touch_event_type;

endpackage

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for touch_slot_tracker_scaler: directed and random raw
// events, several register settings, a local slot tracker predicting points.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tst_pkg::*;
   import tst_tb_pkg::*;

   localparam int SLOTS = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_MIN_X;
   logic [15:0] csr_wdata = '0;

   tst_req_if req ();
   tst_rsp_if rsp ();

   touch_slot_tracker_scaler #(.MAX_SLOTS(SLOTS)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] min_x, max_x, min_y, max_y;
   logic [12:0] view_w, view_h;
   logic [3:0]  mode;
   logic [4:0]  slot_cnt;
   logic        active [SLOTS];
   logic signed [15:0] pos_x [SLOTS];
   logic signed [15:0] pos_y [SLOTS];
   int unsigned cur_slot;

   touch_event_type pending_events[$];
   touch_event_type driven_events[$];
   rsp_type      expected_points[$];
   int           mismatches = 0;
   int           queued_count = 0;

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint scale(longint v, longint lo, longint hi, longint sz);
      if (hi > lo) return (v - lo) * (sz - 1) / (hi - lo);
      return v;
   endfunction

   function automatic int unsigned slots_used();
      if (slot_cnt == 0) return 1;
      if (slot_cnt > SLOTS) return SLOTS;
      return slot_cnt;
   endfunction

   task automatic queue_event(input touch_event_type ev);
      pending_events.insert(pending_events.size(), ev);
      queued_count++;
   endtask

   task automatic apply_cfg(input logic [2:0] idx, input logic [15:0] v);
      case (idx)
         REG_MIN_X:  min_x = v;
         REG_MAX_X:  max_x = v;
         REG_MIN_Y:  min_y = v;
         REG_MAX_Y:  max_y = v;
         REG_VIEW_W: view_w = v[12:0];
         REG_VIEW_H: view_h = v[12:0];
         REG_MODE:   mode = v[3:0];
         default:    slot_cnt = v[4:0];
      endcase
   endtask

   task automatic track_event(input touch_event_type ev);
      int unsigned n, w;
      longint val, x, y, lx, hx, ly, hy, px, py;
      int cnt;
      rsp_type r;
      n = slots_used();
      w = (cur_slot < n) ? cur_slot : n - 1;
      val = ev.event_value;
      if (ev.kind == KIND_ABS) begin
         if (mode[3]) begin
            if (ev.event_code == CODE_SLOT) begin
               if (val < 0) cur_slot = 0;
               else if (val > n - 1) cur_slot = n - 1;
               else cur_slot = val;
            end else if (ev.event_code == CODE_TRACK) active[w] = (val >= 0);
            else if (ev.event_code == CODE_MT_X) pos_x[w] = clip16(val);
            else if (ev.event_code == CODE_MT_Y) pos_y[w] = clip16(val);
         end else begin
            if (ev.event_code == CODE_ABS_X) pos_x[0] = clip16(val);
            else if (ev.event_code == CODE_ABS_Y) pos_y[0] = clip16(val);
         end
         return;
      end
      if (ev.kind == KIND_KEY) begin
         if (!mode[3] && ev.event_code == CODE_TOUCH_KEY) active[0] = (val != 0);
         return;
      end
      if (ev.kind != KIND_SYNC || ev.event_code != CODE_REPORT) return;
      cnt = 0;
      for (int s = 0; s < n; s++) begin
         if (!active[s]) continue;
         x = pos_x[s]; y = pos_y[s];
         lx = min_x; hx = max_x; ly = min_y; hy = max_y;
         if (mode[0]) begin
            x = pos_y[s]; y = pos_x[s];
            lx = min_y; hx = max_y; ly = min_x; hy = max_x;
         end
         px = scale(x, lx, hx, longint'(view_w));
         py = scale(y, ly, hy, longint'(view_h));
         if (mode[1]) px = longint'(view_w) - 1 - px;
         if (mode[2]) py = longint'(view_h) - 1 - py;
         r.point_valid = 1'b1;
         r.slot_index = s[3:0];
         r.disp_x = clip16(px);
         r.disp_y = clip16(py);
         r.last_point = 1'b0;
         expected_points.insert(expected_points.size(), r);
         cnt++;
      end
      if (cnt == 0) begin
         r = '0;
         r.last_point = 1'b1;
         expected_points.insert(expected_points.size(), r);
      end else begin
         expected_points[$].last_point = 1'b1;
      end
   endtask

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            track_event(driven_events.pop_front());
         end
         if (!(req.valid && !req.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               touch_event_type ev;
               ev = pending_events.pop_front();
               driven_events.insert(driven_events.size(), ev);
               req.valid <= 1'b1;
               req.kind <= ev.kind;
               req.event_code <= ev.event_code;
               req.event_value <= ev.event_value;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls on a rotating pattern
   logic [15:0] stall_pat = 16'hf0f0;
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected point: slot %0d x %0d y %0d",
                           rsp.slot_index, rsp.disp_x, rsp.disp_y);
            end else begin
               rsp_type e;
               e = expected_points.pop_front();
               if (e.point_valid !== rsp.point_valid || e.slot_index !== rsp.slot_index ||
                   e.disp_x !== rsp.disp_x || e.disp_y !== rsp.disp_y ||
                   e.last_point !== rsp.last_point) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("point mismatch: exp v%0d s%0d x%0d y%0d l%0d got v%0d s%0d x%0d y%0d l%0d",
                              e.point_valid, e.slot_index, e.disp_x, e.disp_y, e.last_point,
                              rsp.point_valid, rsp.slot_index, rsp.disp_x, rsp.disp_y,
                              rsp.last_point);
               end
            end
         end
         stall_phase++;
         if (stall_phase % 64 == 0) stall_pat <= 16'($urandom);
         rsp.ready <= (stall_phase % 512 < 128) ? 1'b1 : stall_pat[stall_phase % 16];
      end
   end

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_SYNC;
      req.event_code = CODE_REPORT;
      req.event_value = '0;
      rsp.ready = 1'b0;
   end

   function automatic touch_event_type mk(logic [4:0] k, logic [9:0] c,
                                          logic signed [31:0] v);
      touch_event_type ev;
      ev.kind = k; ev.event_code = c; ev.event_value = v;
      return ev;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_cfg(idx, v);
   endtask

   task automatic wait_idle();
      while (pending_events.size() > 0 || driven_events.size() > 0 ||
             expected_points.size() > 0 || req.valid)
         @(posedge clock);
      repeat (2000) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         default: return $signed(32'($urandom_range(0, 4200))) - 50;
      endcase
   endfunction

   // one multi-touch frame: a few slot updates then a sync report
   task automatic queue_mt_frame();
      int k;
      k = $urandom_range(1, 5);
      repeat (k) begin
         queue_event(mk(KIND_ABS, CODE_SLOT, $urandom_range(0, 18) - 1));
         case ($urandom_range(0, 9))
            0: queue_event(mk(KIND_ABS, CODE_TRACK, -1));
            1: queue_event(mk(KIND_ABS, CODE_TRACK, 32'sh80000000));
            default: queue_event(mk(KIND_ABS, CODE_TRACK, $urandom_range(0, 999)));
         endcase
         queue_event(mk(KIND_ABS, CODE_MT_X, rand_pos()));
         queue_event(mk(KIND_ABS, CODE_MT_Y, rand_pos()));
      end
      queue_event(mk(KIND_SYNC, CODE_REPORT, $urandom));
   endtask

   task automatic queue_st_frame();
      queue_event(mk(KIND_ABS, CODE_ABS_X, rand_pos()));
      queue_event(mk(KIND_ABS, CODE_ABS_Y, rand_pos()));
      queue_event(mk(KIND_KEY, CODE_TOUCH_KEY,
                     ($urandom_range(0, 3) == 0) ? 0 : $urandom));
      queue_event(mk(KIND_SYNC, CODE_REPORT, 0));
   endtask

   task automatic queue_noise();
      queue_event(mk(5'($urandom), 10'($urandom), $urandom));
   endtask

   task automatic random_cfg(input int phase);
      logic [15:0] a, b;
      a = 16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 200));
      b = 16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(3000, 4200));
      write_reg(REG_MIN_X, a);
      write_reg(REG_MAX_X, b);
      write_reg(REG_MIN_Y, 16'($urandom_range(0, 4) == 0 ? $urandom : 0));
      write_reg(REG_MAX_Y, 16'($urandom_range(0, 4) == 0 ? $urandom : 4095));
      write_reg(REG_VIEW_W, 16'($urandom_range(0, 8191)));
      write_reg(REG_VIEW_H, 16'($urandom_range(0, 8191)));
      write_reg(REG_MODE, 16'($urandom_range(0, 15)));
      write_reg(REG_SLOTS, 16'($urandom_range(0, 31)));
   endtask

   initial begin
      min_x = 0; max_x = 4095; min_y = 0; max_y = 4095;
      view_w = 1024; view_h = 768; mode = 4'd8; slot_cnt = 5'd1;
      cur_slot = 0;
      for (int i = 0; i < SLOTS; i++) begin
         active[i] = 1'b0; pos_x[i] = '0; pos_y[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: empty frame, single slot with extremes, then sixteen slots with a clamped slot select
      queue_event(mk(KIND_SYNC, CODE_REPORT, 0));
      queue_event(mk(KIND_ABS, CODE_TRACK, 5));
      queue_event(mk(KIND_ABS, CODE_MT_X, 32'sh7fffffff));
      queue_event(mk(KIND_ABS, CODE_MT_Y, 32'sh80000000));
      queue_event(mk(KIND_KEY, CODE_TOUCH_KEY, 0));
      queue_event(mk(5'h1f, 10'h3ff, 32'hffffffff));
      queue_event(mk(KIND_SYNC, CODE_REPORT, 0));
      wait_idle();
      write_reg(REG_SLOTS, 16'd16);
      write_reg(REG_MODE, 16'd15);
      write_reg(REG_VIEW_W, 16'd4096);
      write_reg(REG_VIEW_H, 16'd1);
      queue_event(mk(KIND_ABS, CODE_SLOT, 100));
      queue_event(mk(KIND_ABS, CODE_TRACK, 0));
      queue_event(mk(KIND_ABS, CODE_MT_X, 4095));
      queue_event(mk(KIND_ABS, CODE_MT_Y, -4));
      queue_event(mk(KIND_SYNC, CODE_REPORT, 0));
      wait_idle();
      // stale current slot, degenerate range, zero view size
      write_reg(REG_SLOTS, 16'd3);
      write_reg(REG_MIN_X, 16'h7fff);
      write_reg(REG_MAX_X, 16'h8000);
      write_reg(REG_VIEW_W, 16'd0);
      queue_event(mk(KIND_ABS, CODE_MT_X, 77));
      queue_event(mk(KIND_ABS, CODE_TRACK, 1));
      queue_event(mk(KIND_SYNC, CODE_REPORT, 0));
      wait_idle();
      // single-touch mode
      write_reg(REG_MODE, 16'd0);
      write_reg(REG_VIEW_H, 16'd8191);
      queue_st_frame();
      queue_event(mk(KIND_KEY, CODE_TOUCH_KEY, 1));
      queue_event(mk(KIND_SYNC, CODE_REPORT, 0));
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) begin
            write_reg(REG_MIN_X, 16'h8000); write_reg(REG_MAX_X, 16'h7fff);
            write_reg(REG_MIN_Y, 16'h8000); write_reg(REG_MAX_Y, 16'h7fff);
            write_reg(REG_VIEW_W, 16'd4096); write_reg(REG_VIEW_H, 16'd4096);
            write_reg(REG_MODE, 16'd8); write_reg(REG_SLOTS, 16'd16);
         end else if (phase == 1) begin
            write_reg(REG_MIN_X, 16'd0); write_reg(REG_MAX_X, 16'd4095);
            write_reg(REG_MIN_Y, 16'd0); write_reg(REG_MAX_Y, 16'd4095);
            write_reg(REG_VIEW_W, 16'd1); write_reg(REG_VIEW_H, 16'd1);
            write_reg(REG_MODE, 16'd9); write_reg(REG_SLOTS, 16'd1);
         end else random_cfg(phase);
         while (queued_count < 20 + (phase + 1) * 50) begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 1) queue_noise();
            else if (mode[3] || r < 3) queue_mt_frame();
            else queue_st_frame();
         end
         wait_idle();
      end
      if (mismatches == 0 && expected_points.size() == 0)
         $display("** touch_slot_tracker_scaler: PASSED **");
      else
         $display("** touch_slot_tracker_scaler: FAILED **");
      $finish;
   end

   initial begin
      #100ms;
      $display("** touch_slot_tracker_scaler: FAILED **");
      $finish;
   end

endmodule
